// ===== rtl/lwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lwmm_pkg
// shared constants, opcodes and word layouts of the modulation slot table
// ----------------------------------------------------------------------------
package lwmm_pkg;

  // number of modulation slots, 1 to 255
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 8;
  localparam int VALUE_W = 16;
  localparam int STAMP_W = 32;
  localparam int KEY_W   = 8;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(NUM_SLOTS);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_ROUTE  = 2'd1,
    OP_READ   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  // source memory word
  typedef struct packed {
    logic [STAMP_W-1:0]        stamp;
    logic signed [VALUE_W-1:0] value;
  } source_word_t;

  // route memory word
  typedef struct packed {
    logic             enabled;
    logic [KEY_W-1:0] effect;
    logic [KEY_W-1:0] param;
  } route_word_t;

  localparam int SOURCE_W = $bits(source_word_t);
  localparam int ROUTE_W  = $bits(route_word_t);

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

// ===== rtl/latest_wins_modulation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// latest_wins_modulation_matrix_top
// modulation slot table with update, route, read and latest-wins lookup
// ----------------------------------------------------------------------------
// update and route: written at the accepting edge, busy stays low, no word out
// read: busy while in the read state, done strobe registered from the memory read data
// lookup: busy through the scan state (one slot per cycle through the memory
//   read port), done strobe registered when the last slot's data is in
// the receiver cannot stall: done is high for exactly one cycle
// synchronous reset clears the valid bits, so every slot reads with a zero value and stamp
module latest_wins_modulation_matrix_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lwmm_pkg::OP_W-1:0]           operation,
  input  logic [lwmm_pkg::SLOT_W-1:0]         slot,
  input  logic signed [lwmm_pkg::VALUE_W-1:0] value,
  input  logic [lwmm_pkg::STAMP_W-1:0]        now_ms,
  input  logic [lwmm_pkg::KEY_W-1:0]          effect,
  input  logic [lwmm_pkg::KEY_W-1:0]          param,
  input  logic                                enable,
  output logic                                done,
  output logic                                found,
  output logic signed [lwmm_pkg::VALUE_W-1:0] result_value
);
  import lwmm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } state_t;

  state_t state;

  // accepted word decode
  logic       accept;
  op_t        op;
  logic       in_range;
  logic [IDX_W-1:0] slot_idx;

  assign op       = op_t'(operation);
  assign accept   = start && !busy;
  assign in_range = slot < SLOT_LIMIT;
  assign slot_idx = slot[IDX_W-1:0];
  assign busy     = (state != ST_IDLE);

  // per-entry valid bits stand in for clearing the memories
  logic [NUM_SLOTS-1:0] source_valid;
  logic [NUM_SLOTS-1:0] route_valid;
  logic                 source_vld_q;
  logic                 route_vld_q;

  // memory ports
  logic             source_we;
  logic             route_we;
  logic [IDX_W-1:0] rd_addr;
  source_word_t     source_wdata;
  route_word_t      route_wdata;
  logic [SOURCE_W-1:0] source_rdata;
  logic [ROUTE_W-1:0]  route_rdata;

  assign source_we = accept && (op == OP_UPDATE) && in_range;
  assign route_we  = accept && (op == OP_ROUTE) && in_range;

  always_comb begin
    source_wdata.stamp  = now_ms;
    source_wdata.value  = value;
    route_wdata.enabled = enable;
    route_wdata.effect  = effect;
    route_wdata.param   = param;
  end

  // scan bookkeeping: scan_idx names the slot whose data arrives this cycle
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;
  logic [KEY_W-1:0] key_effect;
  logic [KEY_W-1:0] key_param;
  logic             in_range_q;

  assign scan_last = (scan_idx == LAST_IDX);

  // read address: the request slot, slot zero to open a scan, then the next slot
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = (op == OP_LOOKUP) ? '0 : slot_idx;
    end else if (state == ST_SCAN && !scan_last) begin
      rd_addr = scan_idx + IDX_W'(1);
    end else begin
      rd_addr = scan_idx;
    end
  end

  lwmm_ram #(
    .WIDTH (SOURCE_W),
    .DEPTH (NUM_SLOTS)
  ) u_source_ram (
    .clk   (clk),
    .we    (source_we),
    .waddr (slot_idx),
    .wdata (source_wdata),
    .raddr (rd_addr),
    .rdata (source_rdata)
  );

  lwmm_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (NUM_SLOTS)
  ) u_route_ram (
    .clk   (clk),
    .we    (route_we),
    .waddr (slot_idx),
    .wdata (route_wdata),
    .raddr (rd_addr),
    .rdata (route_rdata)
  );

  source_word_t source_q;
  route_word_t  route_q;

  assign source_q = source_word_t'(source_rdata);
  assign route_q  = route_word_t'(route_rdata);

  // latest-wins tracker
  scan_ctl_t                 scan_ctl;
  logic                      hit_now;
  logic signed [VALUE_W-1:0] value_now;

  always_comb begin
    scan_ctl.clear = accept && (op == OP_LOOKUP);
    scan_ctl.step  = (state == ST_SCAN);
  end

  lwmm_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .key_effect (key_effect),
    .key_param  (key_param),
    .route      (route_q),
    .route_vld  (route_vld_q),
    .source     (source_q),
    .source_vld (source_vld_q),
    .hit_now    (hit_now),
    .value_now  (value_now)
  );

  // valid bits follow the memory read, so they line up with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      source_valid <= '0;
      route_valid  <= '0;
      source_vld_q <= 1'b0;
      route_vld_q  <= 1'b0;
    end else begin
      if (source_we) begin
        source_valid[slot_idx] <= 1'b1;
      end
      if (route_we) begin
        route_valid[slot_idx] <= 1'b1;
      end
      source_vld_q <= source_valid[rd_addr];
      route_vld_q  <= route_valid[rd_addr];
    end
  end

  // request fields held for the duration of the word
  always_ff @(posedge clk) begin
    if (accept) begin
      key_effect <= effect;
      key_param  <= param;
      in_range_q <= in_range;
    end
  end

  // sequencer with registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
      result_value <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            scan_idx <= '0;
            if (op == OP_READ) begin
              state <= ST_READ;
            end else if (op == OP_LOOKUP) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_READ: begin
          // out-of-range reads give found low and zero
          done         <= 1'b1;
          found        <= in_range_q;
          result_value <= (in_range_q && source_vld_q) ? source_q.value : '0;
          state        <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_last) begin
            done         <= 1'b1;
            found        <= hit_now;
            result_value <= hit_now ? value_now : '0;
            state        <= ST_IDLE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lwmm_ram.sv =====
// ----------------------------------------------------------------------------
// lwmm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lwmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lwmm_scan.sv =====
// ----------------------------------------------------------------------------
// lwmm_scan
// latest-timestamp tracker, one slot per step
// ----------------------------------------------------------------------------
module lwmm_scan (
  input  logic                                clk,
  input  lwmm_pkg::scan_ctl_t                 ctl,
  input  logic [lwmm_pkg::KEY_W-1:0]          key_effect,
  input  logic [lwmm_pkg::KEY_W-1:0]          key_param,
  input  lwmm_pkg::route_word_t               route,
  input  logic                                route_vld,
  input  lwmm_pkg::source_word_t              source,
  input  logic                                source_vld,
  output logic                                hit_now,
  output logic signed [lwmm_pkg::VALUE_W-1:0] value_now
);
  import lwmm_pkg::*;

  logic [STAMP_W-1:0]        best_stamp;
  logic signed [VALUE_W-1:0] best_value;
  logic                      best_hit;

  logic [STAMP_W-1:0] stamp;
  logic               match;
  logic               take;

  // never-written entries read with a zero stamp
  assign stamp = source_vld ? source.stamp : '0;
  assign match = route_vld && route.enabled
                 && (route.effect == key_effect) && (route.param == key_param);
  // strict compare keeps the lower index on ties and rejects zero stamps
  assign take  = ctl.step && match && (stamp > best_stamp);

  assign hit_now   = best_hit | take;
  assign value_now = take ? source.value : best_value;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best_stamp <= '0;
      best_value <= '0;
      best_hit   <= 1'b0;
    end else if (take) begin
      best_stamp <= stamp;
      best_value <= source.value;
      best_hit   <= 1'b1;
    end
  end

endmodule
